// ===== rtl/tnp_pkg.sv =====
package tnp_pkg;

    localparam int SUBOPT_LIMIT = 127;
    localparam int HEAD_DEPTH   = 15;
    localparam int CNT_W        = 7;

    // parser states
    localparam logic [2:0] ST_DATA    = 3'd0;
    localparam logic [2:0] ST_IAC     = 3'd1;
    localparam logic [2:0] ST_WILL    = 3'd2;
    localparam logic [2:0] ST_WONT    = 3'd3;
    localparam logic [2:0] ST_DO      = 3'd4;
    localparam logic [2:0] ST_DONT    = 3'd5;
    localparam logic [2:0] ST_SUB     = 3'd6;
    localparam logic [2:0] ST_SUB_IAC = 3'd7;

    // telnet command bytes
    localparam logic [7:0] B_EOR   = 8'd239;
    localparam logic [7:0] B_SE    = 8'd240;
    localparam logic [7:0] B_BREAK = 8'd243;
    localparam logic [7:0] B_SB    = 8'd250;
    localparam logic [7:0] B_WILL  = 8'd251;
    localparam logic [7:0] B_WONT  = 8'd252;
    localparam logic [7:0] B_DO    = 8'd253;
    localparam logic [7:0] B_DONT  = 8'd254;
    localparam logic [7:0] B_IAC   = 8'd255;

    localparam logic [7:0] OPT_TTYPE = 8'd24;
    localparam logic [7:0] OPT_ENV   = 8'd39;

    localparam logic [7:0] SUB_IS   = 8'd0;
    localparam logic [7:0] ENV_VAL  = 8'd1;
    localparam logic [7:0] ENV_USER = 8'd3;

    // events
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_DATA     = 3'd1;
    localparam logic [2:0] EV_REC      = 3'd2;
    localparam logic [2:0] EV_BREAK    = 3'd3;
    localparam logic [2:0] EV_ASK_TT   = 3'd4;
    localparam logic [2:0] EV_ASK_ENV  = 3'd5;
    localparam logic [2:0] EV_TERM_OK  = 3'd6;
    localparam logic [2:0] EV_ENV_DONE = 3'd7;

    localparam logic [7:0] CH_5 = 8'h35;
    localparam logic [7:0] CH_0 = 8'h30;

    typedef logic [7:0][7:0] text8_t;

    // element k holds character k
    localparam text8_t TERM_A = {8'h38, 8'h37, 8'h32, 8'h33, 8'h2d, 8'h4d, 8'h42, 8'h49};
    localparam text8_t TERM_B = {8'h39, 8'h37, 8'h32, 8'h33, 8'h2d, 8'h4d, 8'h42, 8'h49};
    localparam text8_t CP_VAR = {8'h45, 8'h47, 8'h41, 8'h50, 8'h45, 8'h44, 8'h4f, 8'h43};

    typedef logic [HEAD_DEPTH-1:0][7:0] head_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] data_byte;
        logic [7:0] cp_digit_a;
        logic [7:0] cp_digit_b;
        logic [7:0] cp_digit_c;
        logic       cp_default;
    } res_t;

    typedef struct packed {
        logic [2:0] state_next;
        logic       push;
        logic [7:0] push_byte;
        logic       clear;
    } ctl_t;

endpackage

// ===== rtl/tnp_decode.sv =====
module tnp_decode (
    input  logic [2:0]          state,
    input  logic [6:0]          sub_count,
    input  tnp_pkg::head_t      head,
    input  logic [7:0]          rx_octet,
    output tnp_pkg::ctl_t       ctl,
    output tnp_pkg::res_t       res
);
    import tnp_pkg::*;

    head_t hv;
    logic  tt_hdr;
    logic  env_hdr;
    logic  term_hit;
    logic  cp_hit;

    // positions at or past the count read as zero
    always_comb begin
        for (int i = 0; i < HEAD_DEPTH; i++) begin
            hv[i] = (CNT_W'(i) < sub_count) ? head[i] : 8'd0;
        end
    end

    always_comb begin
        logic ma;
        logic mb;
        logic mc;
        ma = 1'b1;
        mb = 1'b1;
        mc = 1'b1;
        for (int k = 0; k < 8; k++) begin
            ma = ma & (hv[2 + k] == TERM_A[k]);
            mb = mb & (hv[2 + k] == TERM_B[k]);
            mc = mc & (hv[3 + k] == CP_VAR[k]);
        end
        term_hit = ma | mb;
        cp_hit   = (hv[2] == ENV_USER) & mc & (hv[11] == ENV_VAL) & (hv[12] != ENV_USER);
    end

    assign tt_hdr  = (sub_count > 7'd2) && (hv[0] == OPT_TTYPE) && (hv[1] == SUB_IS);
    assign env_hdr = (sub_count > 7'd2) && (hv[0] == OPT_ENV) && (hv[1] == SUB_IS);

    always_comb begin
        ctl            = '0;
        ctl.state_next = state;
        ctl.push_byte  = rx_octet;
        res            = '0;
        unique case (state)
            ST_DATA: begin
                if (rx_octet == B_IAC) begin
                    ctl.state_next = ST_IAC;
                end else begin
                    res.event_res = EV_DATA;
                    res.data_byte = rx_octet;
                end
            end
            ST_IAC: begin
                ctl.state_next = ST_DATA;
                case (rx_octet)
                    B_IAC: begin
                        res.event_res = EV_DATA;
                        res.data_byte = B_IAC;
                    end
                    B_WILL:  ctl.state_next = ST_WILL;
                    B_WONT:  ctl.state_next = ST_WONT;
                    B_DO:    ctl.state_next = ST_DO;
                    B_DONT:  ctl.state_next = ST_DONT;
                    B_SB:    ctl.state_next = ST_SUB;
                    B_BREAK: res.event_res = EV_BREAK;
                    B_EOR:   res.event_res = EV_REC;
                    default: ;
                endcase
            end
            ST_WILL: begin
                ctl.state_next = ST_DATA;
                if (rx_octet == OPT_TTYPE) begin
                    res.event_res = EV_ASK_TT;
                end else if (rx_octet == OPT_ENV) begin
                    res.event_res = EV_ASK_ENV;
                end
            end
            ST_WONT, ST_DO, ST_DONT: begin
                ctl.state_next = ST_DATA;
            end
            ST_SUB: begin
                if (rx_octet == B_IAC) begin
                    ctl.state_next = ST_SUB_IAC;
                end else begin
                    ctl.push = 1'b1;
                end
            end
            ST_SUB_IAC: begin
                if (rx_octet == B_IAC) begin
                    ctl.push       = 1'b1;
                    ctl.state_next = ST_SUB;
                end else if (rx_octet == B_SE) begin
                    ctl.clear      = 1'b1;
                    ctl.state_next = ST_DATA;
                    if (tt_hdr) begin
                        if (term_hit) begin
                            res.event_res = EV_TERM_OK;
                        end
                    end else if (env_hdr) begin
                        res.event_res = EV_ENV_DONE;
                        if (cp_hit) begin
                            res.cp_digit_a = hv[12];
                            res.cp_digit_b = hv[13];
                            res.cp_digit_c = hv[14];
                        end else begin
                            res.cp_digit_a = CH_5;
                            res.cp_digit_b = CH_0;
                            res.cp_digit_c = CH_0;
                            res.cp_default = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/telnet_option_receive_parser.sv =====
// Telnet receive parser.
// Input channel (s_valid/s_ready/s_rx_octet) takes one received byte per beat.
// Output channel (m_valid/m_ready/m_*) gives exactly one result beat per input
// beat: an event code with the data byte or code page characters that go with it.
// Each result is registered and appears on the m_ side in the cycle after its
// input beat. Throughput: one byte per cycle while no result waits unread; the
// parse state, suboption count and the first fifteen suboption bytes update in
// the same cycle the byte is taken; the result goes into a single output register.
// While m_ready is low and a result waits, s_ready drops; s_ready follows
// m_ready in the cycle the waiting result is taken, so a new byte can enter
// in that same cycle.
// Reset (aresetn low, synchronous) returns the parser to the data state,
// clears the suboption count and empties the output register.
module telnet_option_receive_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_octet,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_res,
    output logic [7:0] m_data_byte,
    output logic [7:0] m_cp_digit_a,
    output logic [7:0] m_cp_digit_b,
    output logic [7:0] m_cp_digit_c,
    output logic       m_cp_default
);
    import tnp_pkg::*;

    logic [2:0] state_reg;
    logic [6:0] count_reg;
    head_t      head_reg;
    logic       valid_reg;
    res_t       res_reg;
    ctl_t       ctl;
    res_t       res;
    logic       take;

    tnp_decode u_decode (
        .state     (state_reg),
        .sub_count (count_reg),
        .head      (head_reg),
        .rx_octet  (s_rx_octet),
        .ctl       (ctl),
        .res       (res)
    );

    assign s_ready = !valid_reg || m_ready;
    assign take    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_DATA;
            count_reg <= '0;
        end else if (take) begin
            state_reg <= ctl.state_next;
            if (ctl.clear) begin
                count_reg <= '0;
            end else if (ctl.push && (count_reg < CNT_W'(SUBOPT_LIMIT))) begin
                count_reg <= count_reg + 7'd1;
            end
        end
    end

    // reads are masked by the count, so the store needs no reset
    always_ff @(posedge aclk) begin
        if (take && ctl.push && (count_reg < CNT_W'(HEAD_DEPTH))) begin
            head_reg[count_reg[3:0]] <= ctl.push_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res;
        end
    end

    assign m_valid      = valid_reg;
    assign m_event_res  = res_reg.event_res;
    assign m_data_byte  = res_reg.data_byte;
    assign m_cp_digit_a = res_reg.cp_digit_a;
    assign m_cp_digit_b = res_reg.cp_digit_b;
    assign m_cp_digit_c = res_reg.cp_digit_c;
    assign m_cp_default = res_reg.cp_default;

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SUBOPT_LIMIT))
        else $error("suboption count past limit");

    // count only clears at SE, which is the only way out of suboption states
    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SUB && state_reg != ST_SUB_IAC) |-> count_reg == '0)
        else $error("suboption count left nonzero outside suboption");

    a_data_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && state_reg == ST_DATA && s_rx_octet != B_IAC) |=>
        (m_valid && m_event_res == EV_DATA && m_data_byte == $past(s_rx_octet)))
        else $error("plain data byte not passed through");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> m_valid)
        else $error("accepted beat produced no result");

endmodule
